>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, clocked on i_clk, disabled while i_rst_n is low.
`define HDQC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a signal is never high while a guard is high.
`define HDQC_NEVER(lbl, guard, sig, msg) \
    `HDQC_ASSERT(lbl, (guard) |-> !(sig), msg)

`endif

>>> rtl/hdqc_pkg.sv
// ----------------------------------------------------------------------------
// hdqc_pkg
// Types and constants shared by the HDQ-over-UART bit codec.
// ----------------------------------------------------------------------------
package hdqc_pkg;

    localparam logic [7:0] HDQC_MAX_MSG   = 8'd64;
    localparam int         HDQC_QDEPTH    = 4;
    localparam int         HDQC_QAW       = $clog2(HDQC_QDEPTH);

    localparam logic [7:0] HDQC_ONE_RST   = 8'hFE;
    localparam logic [7:0] HDQC_ZERO_RST  = 8'hC0;
    localparam logic [7:0] HDQC_THR_RST   = 8'hF0;

    typedef enum logic [1:0] {
        REG_ONE  = 2'd0,
        REG_ZERO = 2'd1,
        REG_THR  = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        KIND_TX  = 2'd0,
        KIND_RX  = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] one_sym;
        logic [7:0] zero_sym;
        logic [7:0] thr;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] one_sym;
        logic [7:0] zero_sym;
        logic       done;
    } t_job;

endpackage

>>> rtl/hdqc_front.sv
// ----------------------------------------------------------------------------
// hdqc_front
// Classifies words: starts load the echo and bit counters or, if too long, yield
// an error job; received symbols are checked against the echo, sliced and packed into bytes.
// ----------------------------------------------------------------------------
module hdqc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_func,
    input  logic [7:0]        i_cmd_byte,
    input  logic [5:0]        i_rx_count,
    input  logic [7:0]        i_rx_symbol,
    input  hdqc_pkg::t_cfg    i_cfg,
    output logic              o_job_valid,
    output hdqc_pkg::t_job    o_job
);
    import hdqc_pkg::*;

    logic [9:0] r_pos,  n_pos;
    logic [9:0] r_total, n_total;
    logic [7:0] r_asm,  n_asm;
    logic [7:0] r_cmd,  n_cmd;
    logic [7:0] r_one,  n_one;
    logic [7:0] r_zero, n_zero;

    logic [2:0] lo;
    logic       in_echo;
    logic [7:0] expect_sym;
    logic       take;
    logic [7:0] asm_base;
    logic [9:0] pos_inc;
    logic       done;
    logic       emit;
    logic [7:0] msg_len;
    logic       too_long;

    always_comb begin
        lo         = r_pos[2:0];
        in_echo    = (r_pos[9:3] == 7'd0);
        expect_sym = r_cmd[lo] ? r_one : r_zero;
        take       = !(in_echo && (i_rx_symbol != expect_sym)) && (r_pos < r_total);
        asm_base   = (lo == 3'd0) ? 8'd0 : r_asm;
        pos_inc    = r_pos + 10'd1;
        done       = (pos_inc >= r_total);
        emit       = (lo == 3'd7) && (!in_echo || done);
        msg_len    = {2'b00, i_rx_count} + 8'd1;
        too_long   = (msg_len > HDQC_MAX_MSG);
    end

    always_comb begin
        n_pos       = r_pos;
        n_total     = r_total;
        n_asm       = r_asm;
        n_cmd       = r_cmd;
        n_one       = r_one;
        n_zero      = r_zero;
        o_job_valid = 1'b0;
        o_job       = '{kind: KIND_ERR, value: 8'd0, one_sym: r_one,
                        zero_sym: r_zero, done: 1'b0};
        if (i_accept) begin
            if (!i_func) begin
                o_job_valid = 1'b1;
                if (!too_long) begin
                    n_pos   = 10'd0;
                    n_total = {msg_len[6:0], 3'b000};
                    n_cmd   = i_cmd_byte;
                    n_one   = i_cfg.one_sym;
                    n_zero  = i_cfg.zero_sym;
                    o_job   = '{kind: KIND_TX, value: i_cmd_byte,
                                one_sym: i_cfg.one_sym, zero_sym: i_cfg.zero_sym,
                                done: 1'b0};
                end
            end else if (take) begin
                n_asm = asm_base | ((i_rx_symbol >= i_cfg.thr) ? (8'd1 << lo) : 8'd0);
                n_pos = pos_inc;
                if (emit) begin
                    o_job_valid = 1'b1;
                    o_job       = '{kind: KIND_RX, value: n_asm, one_sym: r_one,
                                    zero_sym: r_zero, done: done};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 10'd0;
            r_total <= 10'd0;
            r_asm   <= 8'd0;
            r_cmd   <= 8'd0;
            r_one   <= 8'd0;
            r_zero  <= 8'd0;
        end else begin
            r_pos   <= n_pos;
            r_total <= n_total;
            r_asm   <= n_asm;
            r_cmd   <= n_cmd;
            r_one   <= n_one;
            r_zero  <= n_zero;
        end
    end

endmodule

>>> rtl/hdqc_fifo.sv
// ----------------------------------------------------------------------------
// hdqc_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module hdqc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hdqc_pkg::t_job    i_data,
    output logic              o_full,
    input  logic              i_pop,
    output hdqc_pkg::t_job    o_head,
    output logic              o_empty
);
    import hdqc_pkg::*;

    t_job                r_mem [HDQC_QDEPTH];
    logic [HDQC_QAW-1:0] r_wp, n_wp;
    logic [HDQC_QAW-1:0] r_rp, n_rp;
    logic [HDQC_QAW:0]   r_cnt, n_cnt;
    logic                do_push;
    logic                do_pop;

    always_comb begin
        o_full  = (r_cnt == (HDQC_QAW+1)'(HDQC_QDEPTH));
        o_empty = (r_cnt == '0);
        o_head  = r_mem[r_rp];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wp    = do_push ? r_wp + 1'b1 : r_wp;
        n_rp    = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt   = r_cnt + (HDQC_QAW+1)'(do_push) - (HDQC_QAW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/hdqc_back.sv
// ----------------------------------------------------------------------------
// hdqc_back
// Expands queued jobs into result words: eight transmit symbols per start,
// one word per byte or error, held in an output register.
// ----------------------------------------------------------------------------
module hdqc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hdqc_pkg::t_job    i_head,
    input  logic              i_head_empty,
    output logic              o_head_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_value,
    output logic              o_last,
    output logic              o_done_res
);
    import hdqc_pkg::*;

    logic       r_valid, n_valid;
    logic [2:0] r_idx,   n_idx;
    logic [1:0] r_kind,  n_kind;
    logic [7:0] r_value, n_value;
    logic       r_last,  n_last;
    logic       r_done,  n_done;
    logic       load;
    logic       is_tx;

    always_comb begin
        is_tx      = (i_head.kind == KIND_TX);
        load       = !i_head_empty && (!r_valid || i_pop);
        o_head_pop = load && (!is_tx || (r_idx == 3'd7));
        n_valid    = load ? 1'b1 : (i_pop ? 1'b0 : r_valid);
        n_idx      = (load && is_tx) ? r_idx + 3'd1 : r_idx;
        n_kind     = r_kind;
        n_value    = r_value;
        n_last     = r_last;
        n_done     = r_done;
        if (load) begin
            n_kind = i_head.kind;
            n_done = i_head.done;
            if (is_tx) begin
                n_value = i_head.value[r_idx] ? i_head.one_sym : i_head.zero_sym;
                n_last  = (r_idx == 3'd7);
            end else begin
                n_value = i_head.value;
                n_last  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_last  <= n_last;
        r_done  <= n_done;
    end

    assign o_empty    = !r_valid;
    assign o_kind     = r_kind;
    assign o_value    = r_value;
    assign o_last     = r_last;
    assign o_done_res = r_done;

endmodule

>>> rtl/hdq_over_uart_bit_codec_top.sv
// A result word is written into the job queue and then loaded into the output register.
// The block takes one input word per cycle while the queue is not full; a start within the length
// limit yields 8 result words, one per cycle from the output register while the receiver pops them.
// A 4-entry job queue decouples input from output stalls.
// Reset: synchronous active-low; clears counters, queue and output valid,
// and loads the symbol and threshold registers with 0xFE, 0xC0, 0xF0.
// ----------------------------------------------------------------------------
// hdq_over_uart_bit_codec_top
// HDQ-over-UART bit codec: command symbol encoder and response slicer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdq_over_uart_bit_codec_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_cmd_byte,
    input  logic [5:0]  i_rx_count,
    input  logic [7:0]  i_rx_symbol,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_value,
    output logic        o_last,
    output logic        o_done_res
);
    import hdqc_pkg::*;

    t_cfg r_cfg;
    t_job job;
    t_job head;
    logic job_valid;
    logic accept;
    logic head_empty;
    logic head_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{one_sym: HDQC_ONE_RST, zero_sym: HDQC_ZERO_RST, thr: HDQC_THR_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ONE:  r_cfg.one_sym  <= i_cfg_wdata;
                REG_ZERO: r_cfg.zero_sym <= i_cfg_wdata;
                REG_THR:  r_cfg.thr      <= i_cfg_wdata;
                default:  r_cfg          <= r_cfg;
            endcase
        end
    end

    assign accept = push && !full;

    hdqc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_cmd_byte  (i_cmd_byte),
        .i_rx_count  (i_rx_count),
        .i_rx_symbol (i_rx_symbol),
        .i_cfg       (r_cfg),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    hdqc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job),
        .o_full  (full),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_empty (head_empty)
    );

    hdqc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_last       (o_last),
        .o_done_res   (o_done_res)
    );

    `HDQC_NEVER(a_last_tx_only, !empty && (o_kind != KIND_TX), o_last, "last on non-transmit word")
    `HDQC_NEVER(a_done_rx_only, !empty && (o_kind != KIND_RX), o_done_res, "done on non-data word")
    `HDQC_ASSERT(a_err_clean, (!empty && (o_kind == KIND_ERR)) |-> (o_value == 8'd0), "error word carries data")
    `HDQC_ASSERT(a_no_lost_job, (full && !head_pop) |=> full, "queue lost an entry while stalled")

endmodule

>>> bench/hdq_over_uart_bit_codec_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdq_over_uart_bit_codec_top_tb
// Self-checking bench for the HDQ-over-UART bit codec. A behavioral codec
// class tracks echo, bit count and byte assembly and queues the expected
// result words; every popped word is compared field by field. Stimulus is a
// short directed run followed by randomized command/echo/response sequences
// with noise, register changes, random idling on both sides and a flood
// against a stalled receiver, and ends with a directed longest-message run.
// ----------------------------------------------------------------------------
module hdq_over_uart_bit_codec_top_tb;
    import hdqc_pkg::*;

    localparam bit         FUNC_START     = 1'b0;
    localparam bit         FUNC_SYMBOL    = 1'b1;
    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         IDLE_SETTLE    = 8;
    localparam int         END_SETTLE     = 20;
    localparam int         RX_HOLD_CYCLES = 120;
    localparam int         RANDOM_ITEMS   = 50;

    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
        logic       done;
    } t_codec_word;

    class hdq_echo_slicer;
        logic [7:0]  one_sym;
        logic [7:0]  zero_sym;
        logic [7:0]  thr;
        logic [7:0]  echo [8];
        logic [9:0]  bit_pos;
        logic [9:0]  bit_tot;
        logic [7:0]  asm_byte;
        t_codec_word expected_words [$];
        int          errors;
        int          n_used;
        int          n_starts;
        int          n_bytes;
        int          n_checked;

        function new();
            one_sym  = HDQC_ONE_RST;
            zero_sym = HDQC_ZERO_RST;
            thr      = HDQC_THR_RST;
            foreach (echo[k]) echo[k] = 8'h00;
            bit_pos  = '0;
            bit_tot  = '0;
            asm_byte = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                REG_ONE:  one_sym  = v;
                REG_ZERO: zero_sym = v;
                REG_THR:  thr      = v;
                default: ;
            endcase
        endfunction

        function void accept_input(bit func, logic [7:0] cmd, logic [5:0] cnt,
                                   logic [7:0] sym);
            t_codec_word w;
            logic [9:0]  j;
            if (func == FUNC_START) begin
                n_used++;
                n_starts++;
                if (int'(cnt) + 1 > int'(HDQC_MAX_MSG)) begin
                    w = '{KIND_ERR, 8'h00, 1'b0, 1'b0};
                    expected_words.push_back(w);
                    return;
                end
                bit_pos = '0;
                bit_tot = 10'((int'(cnt) + 1) * 8);
                for (int b = 0; b < 8; b++) begin
                    echo[b] = cmd[b] ? one_sym : zero_sym;
                    w = '{KIND_TX, echo[b], b == 7, 1'b0};
                    expected_words.push_back(w);
                end
                return;
            end
            j = bit_pos;
            if (j < 10'd8 && sym != echo[j[2:0]]) return;
            if (j >= bit_tot) return;
            n_used++;
            if (j[2:0] == 3'd0) asm_byte = 8'h00;
            if (sym >= thr) asm_byte[j[2:0]] = 1'b1;
            bit_pos = j + 10'd1;
            if (j[2:0] == 3'd7 && (j >= 10'd8 || bit_pos >= bit_tot)) begin
                w = '{KIND_RX, asm_byte, 1'b0, bit_pos >= bit_tot};
                expected_words.push_back(w);
                n_bytes++;
            end
        endfunction

        function void compare_output(logic [1:0] kind, logic [7:0] value, logic last,
                                     logic done);
            t_codec_word w;
            n_checked++;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: kind %0d value %02h", kind, value);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (kind !== w.kind) begin
                $error("kind: expected %0d, got %0d", w.kind, kind);
                errors++;
            end
            if (value !== w.value) begin
                $error("value: expected %02h, got %02h", w.value, value);
                errors++;
            end
            if (last !== w.last) begin
                $error("last: expected %0d, got %0d", w.last, last);
                errors++;
            end
            if (done !== w.done) begin
                $error("done_res: expected %0d, got %0d", w.done, done);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_wdata;
    logic       push;
    logic       full;
    logic       i_func;
    logic [7:0] i_cmd_byte;
    logic [5:0] i_rx_count;
    logic [7:0] i_rx_symbol;
    logic       empty;
    logic       pop;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic       o_last;
    logic       o_done_res;

    hdq_echo_slicer codec = new();

    int tx_left, rx_left;
    bit tx_idle, rx_idle;
    bit tx_quiet;
    bit rx_hold;
    int n_sent;
    int n_cfg;

    hdq_over_uart_bit_codec_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_cmd_byte  (i_cmd_byte),
        .i_rx_count  (i_rx_count),
        .i_rx_symbol (i_rx_symbol),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_done_res  (o_done_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Picks at random, for each stretch, between random idling and none.
    function automatic int next_gap(inout int left, inout bit idle);
        if (left == 0) begin
            idle = $urandom_range(0, 1);
            left = $urandom_range(4, 40);
        end
        left--;
        return idle ? $urandom_range(0, 15) : 0;
    endfunction

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_word(bit func, logic [7:0] cmd, logic [5:0] cnt, logic [7:0] sym);
        int gap;
        gap = tx_quiet ? 0 : next_gap(tx_left, tx_idle);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_func      <= func;
        i_cmd_byte  <= cmd;
        i_rx_count  <= cnt;
        i_rx_symbol <= sym;
        do @(posedge i_clk); while (full !== 1'b0);
        codec.accept_input(func, cmd, cnt, sym);
        n_sent++;
    endtask

    task automatic send_start(logic [7:0] cmd, logic [5:0] cnt);
        send_word(FUNC_START, cmd, cnt, 8'($urandom));
    endtask

    task automatic send_symbol(logic [7:0] sym);
        send_word(FUNC_SYMBOL, 8'($urandom), 6'($urandom), sym);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (codec.expected_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] one, logic [7:0] zero, logic [7:0] thr,
                              bit touch_spare);
        logic [1:0] idxs [4];
        logic [7:0] vals [4];
        idxs = '{REG_ONE, REG_ZERO, REG_THR, REG_SPARE};
        vals = '{one, zero, thr, 8'($urandom)};
        for (int k = 0; k < 4; k++) begin
            if (idxs[k] == REG_SPARE && !touch_spare) break;
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            codec.set_reg(idxs[k], vals[k]);
            n_cfg++;
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_transaction(logic [7:0] cmd, logic [5:0] cnt, bit noisy, bit resym);
        logic [7:0] s;
        send_start(cmd, cnt);
        // new symbol codes must not disturb the stored echo
        if (resym) begin
            wait_idle();
            write_regs(pick_reg_value(), pick_reg_value(), codec.thr, 1'b0);
        end
        for (int j = 0; j < 8; j++) begin
            if (noisy && $urandom_range(0, 39) == 0) return;
            if (noisy && $urandom_range(0, 3) == 0) begin
                s = 8'($urandom);
                if (s == codec.echo[j]) s = ~s;
                send_symbol(s);
            end
            send_symbol(codec.echo[j]);
        end
        for (int j = 0; j < int'(cnt) * 8; j++) begin
            if (noisy && $urandom_range(0, 39) == 0) return;
            case ($urandom_range(0, 5))
                0:       s = codec.one_sym;
                1:       s = codec.zero_sym;
                2:       s = codec.thr;
                3:       s = codec.thr - 8'd1;
                default: s = 8'($urandom);
            endcase
            send_symbol(s);
        end
        if (noisy) send_symbol(8'($urandom));
    endtask

    initial begin : result_drain
        int gap;
        pop <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = rx_hold ? RX_HOLD_CYCLES : next_gap(rx_left, rx_idle);
            rx_hold = 1'b0;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            codec.compare_output(o_kind, o_value, o_last, o_done_res);
        end
    end

    initial begin : stimulus
        logic [7:0] probe_syms [8];
        int         rand_base;
        int         n_tx;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_ONE;
        i_cfg_wdata <= 8'h00;
        i_func      <= FUNC_START;
        i_cmd_byte  <= 8'h00;
        i_rx_count  <= 6'd0;
        i_rx_symbol <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // symbols with no transaction open
        send_symbol(8'h00);
        send_symbol(8'hFF);

        // zero-length response: the echo byte itself is reported with done
        send_start(8'hA5, 6'd0);
        for (int j = 0; j < 8; j++) send_symbol(codec.echo[j]);

        // one response byte around the threshold
        probe_syms = '{8'hFF, 8'h00, HDQC_THR_RST, HDQC_THR_RST - 8'd1,
                       HDQC_ONE_RST, HDQC_ZERO_RST, 8'hF1, 8'hEF};
        send_start(8'h00, 6'd1);
        for (int j = 0; j < 8; j++) send_symbol(codec.echo[j]);
        for (int j = 0; j < 8; j++) send_symbol(probe_syms[j]);

        wait_idle();
        write_regs(8'hFF, 8'h00, 8'h80, 1'b1);

        rand_base = codec.n_used;
        n_tx      = 0;
        while (codec.n_used - rand_base < RANDOM_ITEMS) begin
            n_tx++;
            if (n_tx == 2) begin
                // stalled receiver against back-to-back starts
                wait_idle();
                rx_hold  = 1'b1;
                tx_quiet = 1'b1;
                repeat (6) send_start(8'($urandom), 6'($urandom_range(0, 3)));
                tx_quiet = 1'b0;
                wait_idle();
            end
            if (n_tx % 5 == 0) begin
                wait_idle();
                write_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(), 1'b0);
            end
            if ($urandom_range(0, 7) == 0)
                send_word(1'($urandom), 8'($urandom), 6'($urandom), 8'($urandom));
            run_transaction(8'($urandom), 6'($urandom_range(0, 3)),
                            $urandom_range(0, 2) != 0, $urandom_range(0, 5) == 0);
        end

        // longest allowed message: echo plus the first two response bytes
        wait_idle();
        write_regs(HDQC_ONE_RST, HDQC_ZERO_RST, HDQC_THR_RST, 1'b0);
        send_start(8'hFF, 6'd63);
        for (int j = 0; j < 8; j++) send_symbol(codec.echo[j]);
        for (int j = 0; j < 16; j++) send_symbol(8'($urandom));

        push <= 1'b0;
        while (codec.expected_words.size() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Covered %0d input words (%0d starts, %0d register writes).",
                 n_sent, codec.n_starts, n_cfg);
        $display("Checked %0d result words, %0d of them decoded bytes.",
                 codec.n_checked, codec.n_bytes);
        if (codec.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
